// File: rtl/core/gpds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpds_pkg: shared definitions for the grid point squared diameter block
// Default sizes, fixed port widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package gpds_pkg;

	// default table size and used column width
	localparam int ROWS_DEF     = 256;
	localparam int COL_BITS_DEF = 16;

	// fixed port widths
	localparam int COL_IN_W = 16;
	localparam int ROW_IN_W = 8;
	localparam int OUT_W    = 32;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // point request taken this cycle
		logic clr_wr;    // clearing write at controller address
		logic scan_rd;   // table read at controller address
		logic scan_tag;  // this read is a partner row of the scan
		logic latch_a;   // capture read data as the anchor row
		logic best_clr;  // restart the running maximum
		logic emit;      // load the result register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic rd_valid;   // row just read holds points
		logic pipe_busy;  // scoring pipeline not yet empty
		logic out_free;   // result register can take a new value
	} sts_t;

endpackage

// File: rtl/core/grid_point_diameter_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_point_diameter_square: squared diameter of a set of grid points
// Keeps per-row column extremes and scores all extreme pairs on the last point.
// ----------------------------------------------------------------------------
// Usage:
//   point channel: one (col, row) request per accepted cycle, last marks the
//   final point of a set. Points stream in at one per cycle while loading;
//   a point whose row is at or beyond ROWS is dropped.
//   result channel: one diam_sq request per set, the largest
//   squared distance between row extremes, saturated to 32 bits.
// Scan: after the last point every row is read once as an anchor, and each
//   occupied anchor is paired with every row; then the scoring pipeline drains
//   and the result is handed off. The scan is set by the single table read port,
//   one partner row per cycle for every occupied anchor row.
// Clearing: after the result is loaded the table valid marks are cleared,
//   then point requests are taken again.
// Reset: the table is cleared before the first point request is taken;
//   point_stall stays high meanwhile.
// Stall: the result sits in an output register; a stalled result holds and
//   the next set loads behind it. A new result waits until that one is taken.
// ----------------------------------------------------------------------------
module grid_point_diameter_square #(
	parameter int ROWS     = gpds_pkg::ROWS_DEF,
	parameter int COL_BITS = gpds_pkg::COL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  logic [gpds_pkg::COL_IN_W-1:0] col,
	input  logic [gpds_pkg::ROW_IN_W-1:0] row,
	input  logic                          last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [gpds_pkg::OUT_W-1:0]    diam_sq
);
	import gpds_pkg::*;

	cmd_t                    cmd;
	sts_t                    sts;
	logic [$clog2(ROWS)-1:0] addr;

	// sequencer
	gpds_ctrl #(
		.ROWS (ROWS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.last        (last),
		.point_stall (point_stall),
		.cmd         (cmd),
		.sts         (sts),
		.addr        (addr)
	);

	// table and scoring datapath
	gpds_dpath #(
		.ROWS     (ROWS),
		.COL_BITS (COL_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.addr         (addr),
		.col          (col),
		.row          (row),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.diam_sq      (diam_sq)
	);

endmodule

// File: rtl/core/gpds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpds_ram: generic simple dual port memory
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module gpds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/gpds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpds_ctrl: sequencer for the squared diameter block
// Runs table clearing, point loading, the row pair scan and result hand-off.
// ----------------------------------------------------------------------------
module gpds_ctrl #(
	parameter int ROWS = gpds_pkg::ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      point_valid,
	input  logic                      last,
	output logic                      point_stall,
	output gpds_pkg::cmd_t            cmd,
	input  gpds_pkg::sts_t            sts,
	output logic [$clog2(ROWS)-1:0]   addr
);
	import gpds_pkg::*;

	localparam int ROW_W = $clog2(ROWS);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_RDI   = 3'd3;
	localparam logic [2:0] ST_GETI  = 3'd4;
	localparam logic [2:0] ST_SCANJ = 3'd5;
	localparam logic [2:0] ST_FLUSH = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [ROW_W-1:0] i_q, i_d, j_q, j_d;
	logic             i_end, j_end;

	assign i_end = (i_q == LAST_ROW);
	assign j_end = (j_q == LAST_ROW);

	// requests are taken only while loading
	assign point_stall = (state_q != ST_LOAD);

	// next state, counters and commands
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		cmd     = '0;
		addr    = j_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				j_d        = j_q + 1'b1;
				if (j_end) begin
					j_d     = '0;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = point_valid;
				if (point_valid && last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last point is written back in this cycle
				i_d          = '0;
				cmd.best_clr = 1'b1;
				state_d      = ST_RDI;
			end
			ST_RDI: begin
				cmd.scan_rd = 1'b1;
				addr        = i_q;
				state_d     = ST_GETI;
			end
			ST_GETI: begin
				cmd.latch_a = 1'b1;
				if (sts.rd_valid) begin
					j_d     = '0;
					state_d = ST_SCANJ;
				end else if (i_end) begin
					state_d = ST_FLUSH;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_RDI;
				end
			end
			ST_SCANJ: begin
				cmd.scan_rd  = 1'b1;
				cmd.scan_tag = 1'b1;
				j_d          = j_q + 1'b1;
				if (j_end) begin
					if (i_end) begin
						state_d = ST_FLUSH;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = ST_RDI;
					end
				end
			end
			ST_FLUSH: begin
				if (!sts.pipe_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					j_d      = '0;
					state_d  = ST_CLEAR;
				end
			end
			default: begin
				state_d = ST_CLEAR;
				j_d     = '0;
			end
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

endmodule

// File: rtl/core/gpds_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpds_dpath: row table and scoring datapath
// Row extreme table with read-modify-write load, pair scoring pipeline,
// running maximum and the result register.
// ----------------------------------------------------------------------------
module gpds_dpath #(
	parameter int ROWS     = gpds_pkg::ROWS_DEF,
	parameter int COL_BITS = gpds_pkg::COL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gpds_pkg::cmd_t                cmd,
	output gpds_pkg::sts_t                sts,
	input  logic [$clog2(ROWS)-1:0]       addr,
	input  logic [gpds_pkg::COL_IN_W-1:0] col,
	input  logic [gpds_pkg::ROW_IN_W-1:0] row,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [gpds_pkg::OUT_W-1:0]    diam_sq
);
	import gpds_pkg::*;

	localparam int ROW_W   = $clog2(ROWS);
	localparam int WORD_W  = 1 + 2 * COL_BITS;
	localparam int SQ_W    = (2 * COL_BITS > 2 * ROW_W) ? 2 * COL_BITS : 2 * ROW_W;
	localparam int SCORE_W = (SQ_W + 1 > OUT_W + 1) ? SQ_W + 1 : OUT_W + 1;

	// table port signals; word is {valid, leftmost, rightmost}
	logic              we;
	logic [ROW_W-1:0]  waddr, raddr, raddr_q;
	logic [WORD_W-1:0] wdata, rdata;

	gpds_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROWS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	logic                rd_v;
	logic [COL_BITS-1:0] rd_left, rd_right;

	assign rd_v     = rdata[WORD_W-1];
	assign rd_left  = rdata[2*COL_BITS-1:COL_BITS];
	assign rd_right = rdata[COL_BITS-1:0];

	// load stage: point waits for its row read
	logic                ld_v_s1, ld_in_s1;
	logic [ROW_W-1:0]    ld_row_s1;
	logic [COL_BITS-1:0] ld_col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1 <= 1'b0;
		end else begin
			ld_v_s1 <= cmd.load;
		end
	end

	always_ff @(posedge clk) begin
		ld_in_s1  <= (32'(row) < 32'(ROWS));
		ld_row_s1 <= ROW_W'(row);
		ld_col_s1 <= COL_BITS'(col);
	end

	// last write bypass, covers a read that collides with a write
	logic              fwd_v_q;
	logic [ROW_W-1:0]  fwd_addr_q;
	logic [WORD_W-1:0] fwd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fwd_addr_q <= waddr;
			fwd_data_q <= wdata;
		end
	end

	// merge the point into its row extremes
	logic [WORD_W-1:0]   cur, merged;
	logic [COL_BITS-1:0] cur_left, cur_right, new_left, new_right;

	always_comb begin
		cur       = (fwd_v_q && (fwd_addr_q == ld_row_s1)) ? fwd_data_q : rdata;
		cur_left  = cur[2*COL_BITS-1:COL_BITS];
		cur_right = cur[COL_BITS-1:0];
		new_left  = ld_col_s1;
		new_right = ld_col_s1;
		if (cur[WORD_W-1]) begin
			new_left  = (ld_col_s1 < cur_left) ? ld_col_s1 : cur_left;
			new_right = (ld_col_s1 > cur_right) ? ld_col_s1 : cur_right;
		end
		merged = {1'b1, new_left, new_right};
	end

	// table port muxing
	assign we    = cmd.clr_wr | (ld_v_s1 & ld_in_s1);
	assign waddr = cmd.clr_wr ? addr : ld_row_s1;
	assign wdata = cmd.clr_wr ? '0 : merged;
	assign raddr = cmd.scan_rd ? addr : ROW_W'(row);

	// track what the read data belongs to
	logic tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= 1'b0;
		end else begin
			tag_q <= cmd.scan_tag;
		end
	end

	always_ff @(posedge clk) begin
		raddr_q <= raddr;
	end

	// anchor row of the outer scan loop
	logic [ROW_W-1:0]    a_row_q;
	logic [COL_BITS-1:0] a_left_q, a_right_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_a) begin
			a_row_q   <= raddr_q;
			a_left_q  <= rd_left;
			a_right_q <= rd_right;
		end
	end

	// scoring stage 1: absolute differences
	logic                sc_v_s1, sc_v_s2, sc_v_s3;
	logic [ROW_W-1:0]    sc_dr_s1;
	logic [COL_BITS-1:0] sc_dlr_s1, sc_dll_s1, sc_drr_s1;

	always_ff @(posedge clk) begin
		sc_dr_s1  <= (a_row_q > raddr_q) ? a_row_q - raddr_q : raddr_q - a_row_q;
		sc_dlr_s1 <= (a_left_q > rd_right) ? a_left_q - rd_right : rd_right - a_left_q;
		sc_dll_s1 <= (a_left_q > rd_left) ? a_left_q - rd_left : rd_left - a_left_q;
		sc_drr_s1 <= (a_right_q > rd_right) ? a_right_q - rd_right : rd_right - a_right_q;
	end

	// scoring stage 2: squares
	logic [2*ROW_W-1:0]    sc_dr2_s2;
	logic [2*COL_BITS-1:0] sc_lr2_s2, sc_ll2_s2, sc_rr2_s2;

	always_ff @(posedge clk) begin
		sc_dr2_s2 <= (2*ROW_W)'(sc_dr_s1) * (2*ROW_W)'(sc_dr_s1);
		sc_lr2_s2 <= (2*COL_BITS)'(sc_dlr_s1) * (2*COL_BITS)'(sc_dlr_s1);
		sc_ll2_s2 <= (2*COL_BITS)'(sc_dll_s1) * (2*COL_BITS)'(sc_dll_s1);
		sc_rr2_s2 <= (2*COL_BITS)'(sc_drr_s1) * (2*COL_BITS)'(sc_drr_s1);
	end

	// scoring stage 3: row term plus column term
	logic [SCORE_W-1:0] sc_lr_s3, sc_ll_s3, sc_rr_s3;

	always_ff @(posedge clk) begin
		sc_lr_s3 <= SCORE_W'(sc_dr2_s2) + SCORE_W'(sc_lr2_s2);
		sc_ll_s3 <= SCORE_W'(sc_dr2_s2) + SCORE_W'(sc_ll2_s2);
		sc_rr_s3 <= SCORE_W'(sc_dr2_s2) + SCORE_W'(sc_rr2_s2);
	end

	// stage valids, only occupied partner rows count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_v_s1 <= 1'b0;
			sc_v_s2 <= 1'b0;
			sc_v_s3 <= 1'b0;
		end else begin
			sc_v_s1 <= tag_q & rd_v;
			sc_v_s2 <= sc_v_s1;
			sc_v_s3 <= sc_v_s2;
		end
	end

	// running maximum
	logic [SCORE_W-1:0] best_q, max_a, max_b;

	assign max_a = (sc_lr_s3 > sc_ll_s3) ? sc_lr_s3 : sc_ll_s3;
	assign max_b = (max_a > sc_rr_s3) ? max_a : sc_rr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (cmd.best_clr) begin
			best_q <= '0;
		end else if (sc_v_s3 && (max_b > best_q)) begin
			best_q <= max_b;
		end
	end

	// result register with saturation
	logic             res_v_q;
	logic [OUT_W-1:0] res_q;
	logic             res_take;

	assign res_take = res_v_q & ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (cmd.emit) begin
			res_v_q <= 1'b1;
		end else if (res_take) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q <= (|best_q[SCORE_W-1:OUT_W]) ? '1 : best_q[OUT_W-1:0];
		end
	end

	assign result_valid = res_v_q;
	assign diam_sq      = res_q;

	// status back to the controller
	always_comb begin
		sts.rd_valid  = rd_v;
		sts.pipe_busy = tag_q | sc_v_s1 | sc_v_s2 | sc_v_s3;
		sts.out_free  = ~res_v_q | ~result_stall;
	end

endmodule

// File: rtl/core/gpds_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpds_chk: port level checks for the squared diameter block
// Watches the point and result channels and flags ordering slips.
// ----------------------------------------------------------------------------
module gpds_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          point_valid,
	input logic                          point_stall,
	input logic [gpds_pkg::COL_IN_W-1:0] col,
	input logic [gpds_pkg::ROW_IN_W-1:0] row,
	input logic                          last,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [gpds_pkg::OUT_W-1:0]    diam_sq
);

	// a stalled result request holds its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(diam_sq))
		else $error("stalled result changed");

	// the block goes busy right after taking the last point of a set
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall && last |=> point_stall)
		else $error("point taken right after last point");

	// a new result only appears while points are held off
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> point_stall && $past(point_stall))
		else $error("result appeared while loading points");

	// no result without a prior accepted set end: nothing in the first loading cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(point_stall) && !$past(result_valid) |-> !$rose(result_valid))
		else $error("result appeared as loading began");

	// columns and rows are only watched for known values while a point is offered
	a_point_known: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> !$isunknown({col, row, last}))
		else $error("unknown point payload");

endmodule

bind grid_point_diameter_square gpds_chk u_chk (.*);
